// ===== hdl/aco_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Aho-Corasick matcher package
// Sizes, command and status codes, and the goto table index function.
// ----------------------------------------------------------------------------
package aco_pkg;

	localparam int NODES      = 1024;
	localparam int ALPHABET   = 26;
	localparam int NODE_W     = $clog2(NODES);
	localparam int CNT_W      = NODE_W + 1;
	localparam int LTR_W      = 5;
	localparam int LEN_W      = 10;
	localparam int GOTO_DEPTH = NODES * ALPHABET;
	localparam int GOTO_W     = $clog2(GOTO_DEPTH);

	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_BUILD  = 2'd1;
	localparam logic [1:0] CMD_MATCH  = 2'd2;
	localparam logic [1:0] CMD_RSVD   = 2'd3;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_IGNORED = 2'd2
	} status_t;

	function automatic logic [GOTO_W-1:0] goto_idx(input logic [NODE_W-1:0] node,
			input logic [LTR_W-1:0] ltr);
		goto_idx = GOTO_W'(node) * GOTO_W'(ALPHABET) + GOTO_W'(ltr);
	endfunction

endpackage
`default_nettype wire

// ===== hdl/aho_corasick_matcher.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Aho-Corasick matcher
// An ignored command or a letter of a dropped pattern is answered from idle;
// a match letter passes S_MT_LEN and S_MT_OUT, an insert letter S_INS_CHK and,
// if it ends a pattern at an existing node, S_INS_MARK. A build takes each
// queued trie node through S_BLD_Q, S_BLD_U and S_BLD_F, and each node and
// letter pair through S_BLD_RD, S_BLD_CHK and, for a child, S_BLD_WR.
// One transaction at a time; done strobes each result for one cycle and the
// receiver cannot stall. After reset a clearing pass keeps busy high.
// ----------------------------------------------------------------------------
module aho_corasick_matcher (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	output logic                            busy,
	input  wire logic [1:0]                 cmd,
	input  wire logic [aco_pkg::LTR_W-1:0]  letter,
	input  wire logic                       pattern_end,
	input  wire logic                       text_start,
	output logic                            done,
	output logic [aco_pkg::LEN_W-1:0]       match_len,
	output logic [1:0]                      status
);
	import aco_pkg::*;

	typedef enum logic [11:0] {
		S_CLEAR    = 12'b000000000001,
		S_IDLE     = 12'b000000000010,
		S_INS_CHK  = 12'b000000000100,
		S_INS_MARK = 12'b000000001000,
		S_BLD_Q    = 12'b000000010000,
		S_BLD_U    = 12'b000000100000,
		S_BLD_F    = 12'b000001000000,
		S_BLD_RD   = 12'b000010000000,
		S_BLD_CHK  = 12'b000100000000,
		S_BLD_WR   = 12'b001000000000,
		S_MT_LEN   = 12'b010000000000,
		S_MT_OUT   = 12'b100000000000
	} state_t;

	state_t state_q;
	logic [GOTO_W-1:0] clr_q;
	logic [CNT_W-1:0] node_count_q, head_q, tail_q;
	logic [NODE_W-1:0] cursor_q, match_q, u_q, f_q, v_q, fv_q;
	logic [LTR_W-1:0] letter_q, c_q;
	logic built_q, dropping_q, last_q, root_pass_q;
	logic done_q;
	logic [LEN_W-1:0] match_len_q;
	status_t status_q;

	logic [NODE_W-1:0] goto_mem [GOTO_DEPTH];
	logic [NODE_W-1:0] fl_mem [NODES];
	logic [LEN_W-1:0] ol_mem [NODES];
	logic [NODE_W-1:0] nd_mem [NODES];
	logic [NODE_W-1:0] q_mem [NODES];

	logic [NODE_W-1:0] goto_rd_a, goto_rd_b, fl_rd, q_rd, depth_rd;
	logic [LEN_W-1:0] ol_rd_a, ol_rd_b;

	logic [GOTO_W-1:0] go_ra_a, go_ra_b, go_wa;
	logic [NODE_W-1:0] go_wd;
	logic go_we;
	logic [NODE_W-1:0] nd_ra, nd_wa, nd_wd;
	logic nd_we;
	logic [NODE_W-1:0] ol_ra_a, ol_ra_b, ol_wa;
	logic [LEN_W-1:0] ol_wd;
	logic ol_we;
	logic [NODE_W-1:0] fl_wa, fl_wd;
	logic fl_we;

	logic accept, clr_low, full, ins_new, c_last;
	logic [NODE_W-1:0] sel_node, new_node, fv_now;

	assign busy      = (state_q != S_IDLE);
	assign accept    = start && !busy;
	assign done      = done_q;
	assign match_len = match_len_q;
	assign status    = status_q;

	assign clr_low  = (clr_q < GOTO_W'(NODES));
	assign full     = (node_count_q >= CNT_W'(NODES - 1));
	assign ins_new  = (state_q == S_INS_CHK) && (goto_rd_a == '0) && !full;
	assign new_node = NODE_W'(node_count_q + CNT_W'(1));
	assign sel_node = (cmd == CMD_MATCH) ? (text_start ? '0 : match_q) : cursor_q;
	assign fv_now   = root_pass_q ? '0 : goto_rd_b;
	assign c_last   = (c_q == LTR_W'(ALPHABET - 1));

	always_comb begin
		go_ra_a = (state_q == S_IDLE) ? goto_idx(sel_node, letter) : goto_idx(u_q, c_q);
		go_ra_b = goto_idx(f_q, c_q);
		go_we = 1'b0;
		go_wa = goto_idx(u_q, c_q);
		go_wd = fv_now;
		nd_ra = (state_q == S_INS_CHK) ? goto_rd_a : cursor_q;
		nd_we = 1'b0;
		nd_wa = new_node;
		nd_wd = depth_rd + NODE_W'(1);
		ol_ra_a = goto_rd_a;
		ol_ra_b = fv_now;
		ol_we = 1'b0;
		ol_wa = v_q;
		ol_wd = (ol_rd_a == '0) ? ol_rd_b : ol_rd_a;
		fl_we = 1'b0;
		fl_wa = v_q;
		fl_wd = fv_q;
		case (state_q)
			S_CLEAR: begin
				go_we = 1'b1;
				go_wa = clr_q;
				go_wd = '0;
				nd_we = clr_low;
				nd_wa = clr_q[NODE_W-1:0];
				nd_wd = '0;
				ol_we = clr_low;
				ol_wa = clr_q[NODE_W-1:0];
				ol_wd = '0;
				fl_we = clr_low;
				fl_wa = clr_q[NODE_W-1:0];
				fl_wd = '0;
			end
			S_INS_CHK: begin
				go_we = ins_new;
				go_wa = goto_idx(cursor_q, letter_q);
				go_wd = new_node;
				nd_we = ins_new;
				ol_we = ins_new && last_q;
				ol_wa = new_node;
				ol_wd = LEN_W'(depth_rd + NODE_W'(1));
			end
			S_INS_MARK: begin
				ol_we = 1'b1;
				ol_wd = LEN_W'(depth_rd);
			end
			S_BLD_CHK: begin
				go_we = (goto_rd_a == '0);
			end
			S_BLD_WR: begin
				ol_we = 1'b1;
				fl_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (go_we) begin
			goto_mem[go_wa] <= go_wd;
		end
		goto_rd_a <= goto_mem[go_ra_a];
		goto_rd_b <= goto_mem[go_ra_b];
	end

	always_ff @(posedge clk) begin
		if (nd_we) begin
			nd_mem[nd_wa] <= nd_wd;
		end
		depth_rd <= nd_mem[nd_ra];
	end

	always_ff @(posedge clk) begin
		if (ol_we) begin
			ol_mem[ol_wa] <= ol_wd;
		end
		ol_rd_a <= ol_mem[ol_ra_a];
		ol_rd_b <= ol_mem[ol_ra_b];
	end

	always_ff @(posedge clk) begin
		if (fl_we) begin
			fl_mem[fl_wa] <= fl_wd;
		end
		fl_rd <= fl_mem[q_rd];
	end

	always_ff @(posedge clk) begin
		if (state_q == S_BLD_WR) begin
			q_mem[tail_q[NODE_W-1:0]] <= v_q;
		end
		q_rd <= q_mem[head_q[NODE_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_q        <= '0;
			node_count_q <= '0;
			head_q       <= '0;
			tail_q       <= '0;
			cursor_q     <= '0;
			match_q      <= '0;
			u_q          <= '0;
			f_q          <= '0;
			c_q          <= '0;
			built_q      <= 1'b0;
			dropping_q   <= 1'b0;
			root_pass_q  <= 1'b0;
			done_q       <= 1'b0;
			match_len_q  <= '0;
			status_q     <= ST_OK;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + GOTO_W'(1);
					if (clr_q == GOTO_W'(GOTO_DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						letter_q    <= letter;
						last_q      <= pattern_end;
						match_len_q <= '0;
						status_q    <= ST_IGNORED;
						done_q      <= 1'b1;
						case (cmd)
							CMD_INSERT: begin
								if (!built_q && letter < LTR_W'(ALPHABET)) begin
									if (dropping_q) begin
										status_q <= ST_FULL;
										if (pattern_end) begin
											cursor_q   <= '0;
											dropping_q <= 1'b0;
										end
									end else begin
										done_q  <= 1'b0;
										state_q <= S_INS_CHK;
									end
								end
							end
							CMD_BUILD: begin
								if (!built_q) begin
									done_q      <= 1'b0;
									u_q         <= '0;
									f_q         <= '0;
									c_q         <= '0;
									head_q      <= '0;
									tail_q      <= '0;
									root_pass_q <= 1'b1;
									state_q     <= S_BLD_RD;
								end
							end
							CMD_MATCH: begin
								if (built_q && letter < LTR_W'(ALPHABET)) begin
									done_q  <= 1'b0;
									state_q <= S_MT_LEN;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_INS_CHK: begin
					done_q   <= 1'b1;
					status_q <= ST_OK;
					state_q  <= S_IDLE;
					if (goto_rd_a == '0) begin
						if (full) begin
							status_q   <= ST_FULL;
							dropping_q <= !last_q;
							if (last_q) begin
								cursor_q <= '0;
							end
						end else begin
							node_count_q <= node_count_q + CNT_W'(1);
							cursor_q     <= last_q ? '0 : new_node;
						end
					end else if (last_q) begin
						done_q  <= 1'b0;
						v_q     <= goto_rd_a;
						state_q <= S_INS_MARK;
					end else begin
						cursor_q <= goto_rd_a;
					end
				end
				S_INS_MARK: begin
					cursor_q <= '0;
					done_q   <= 1'b1;
					state_q  <= S_IDLE;
				end
				S_BLD_Q: begin
					state_q <= S_BLD_U;
				end
				S_BLD_U: begin
					u_q     <= q_rd;
					head_q  <= head_q + CNT_W'(1);
					state_q <= S_BLD_F;
				end
				S_BLD_F: begin
					f_q     <= fl_rd;
					c_q     <= '0;
					state_q <= S_BLD_RD;
				end
				S_BLD_RD: begin
					state_q <= S_BLD_CHK;
				end
				S_BLD_CHK, S_BLD_WR: begin
					if (state_q == S_BLD_CHK && goto_rd_a != '0) begin
						v_q     <= goto_rd_a;
						fv_q    <= fv_now;
						state_q <= S_BLD_WR;
					end else begin
						if (state_q == S_BLD_WR) begin
							tail_q <= tail_q + CNT_W'(1);
						end
						if (!c_last) begin
							c_q     <= c_q + LTR_W'(1);
							state_q <= S_BLD_RD;
						end else if (head_q < tail_q + CNT_W'(state_q == S_BLD_WR)) begin
							root_pass_q <= 1'b0;
							state_q     <= S_BLD_Q;
						end else begin
							cursor_q    <= '0;
							dropping_q  <= 1'b0;
							match_q     <= '0;
							built_q     <= 1'b1;
							root_pass_q <= 1'b0;
							done_q      <= 1'b1;
							status_q    <= ST_OK;
							state_q     <= S_IDLE;
						end
					end
				end
				S_MT_LEN: begin
					match_q <= goto_rd_a;
					state_q <= S_MT_OUT;
				end
				S_MT_OUT: begin
					match_len_q <= ol_rd_a;
					status_q    <= ST_OK;
					done_q      <= 1'b1;
					state_q     <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_no_done_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> !done_q)
		else $error("result strobed during the clearing pass");

	a_node_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		node_count_q <= CNT_W'(NODES - 1))
		else $error("node count beyond trie capacity");

	a_len_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && match_len_q != '0) |-> (status_q == ST_OK))
		else $error("nonzero match length on a failed transaction");

	a_built_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		built_q |=> built_q)
		else $error("built flag cleared without reset");

endmodule
`default_nettype wire

// ===== tb/aho_corasick_matcher_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Aho-Corasick matcher testbench
// Fills the trie with random patterns until it overflows, builds the automaton
// and streams text through it. Every result is checked against a predictor
// that keeps its own copy of the trie, failure links and pattern lengths.
// ----------------------------------------------------------------------------
module aho_corasick_matcher_tb;
	import aco_pkg::*;

	class aco_scoreboard;
		typedef struct {
			logic [LEN_W-1:0] len;
			status_t          st;
		} answer_t;

		int unsigned trans [GOTO_DEPTH];
		int unsigned fail_lk [NODES];
		int unsigned pat_len [NODES];
		int unsigned depth_of [NODES];
		int unsigned node_cnt;
		int unsigned cursor;
		int unsigned state_now;
		bit          built;
		bit          dropping;
		answer_t     answers [$];
		int          errors;
		int          n_full;
		int          n_hits;
		int          n_ignored;
		int          n_results;

		function new();
			node_cnt  = 0;
			cursor    = 0;
			state_now = 0;
			built     = 0;
			dropping  = 0;
			errors    = 0;
			n_full    = 0;
			n_hits    = 0;
			n_ignored = 0;
			n_results = 0;
		endfunction

		task report(string msg);
			$display("MISMATCH at %0t: %s", $time, msg);
			errors++;
		endtask

		function status_t add_letter(int unsigned c, bit last);
			status_t     st;
			int unsigned nxt;
			st = ST_OK;
			if (dropping) begin
				st = ST_FULL;
			end else begin
				nxt = trans[cursor * ALPHABET + c];
				if (nxt == 0) begin
					if (node_cnt >= NODES - 1) begin
						dropping = 1;
						st = ST_FULL;
					end else begin
						node_cnt++;
						nxt = node_cnt;
						trans[cursor * ALPHABET + c] = nxt;
						depth_of[nxt] = depth_of[cursor] + 1;
					end
				end
				if (st == ST_OK) begin
					cursor = nxt;
					if (last)
						pat_len[nxt] = depth_of[nxt];
				end
			end
			if (last) begin
				cursor = 0;
				dropping = 0;
			end
			return st;
		endfunction

		function void build_links();
			int unsigned fifo [$];
			int unsigned u, f, v, fv;
			for (int c = 0; c < ALPHABET; c++) begin
				v = trans[c];
				if (v != 0) begin
					fail_lk[v] = 0;
					fifo.push_back(v);
				end
			end
			while (fifo.size() > 0) begin
				u = fifo.pop_front();
				f = fail_lk[u];
				for (int c = 0; c < ALPHABET; c++) begin
					v = trans[u * ALPHABET + c];
					fv = trans[f * ALPHABET + c];
					if (v != 0) begin
						fail_lk[v] = fv;
						if (pat_len[v] == 0)
							pat_len[v] = pat_len[fv];
						fifo.push_back(v);
					end else begin
						trans[u * ALPHABET + c] = fv;
					end
				end
			end
			cursor = 0;
			dropping = 0;
			state_now = 0;
			built = 1;
		endfunction

		function void note(logic [1:0] c, logic [LTR_W-1:0] l, logic pe, logic ts);
			answer_t a;
			a.len = '0;
			a.st = ST_IGNORED;
			if (c == CMD_INSERT) begin
				if (!built && l < ALPHABET)
					a.st = add_letter(l, pe);
			end else if (c == CMD_BUILD) begin
				if (!built) begin
					build_links();
					a.st = ST_OK;
				end
			end else if (c == CMD_MATCH) begin
				if (built && l < ALPHABET) begin
					if (ts)
						state_now = 0;
					state_now = trans[state_now * ALPHABET + l];
					a.len = LEN_W'(pat_len[state_now]);
					a.st = ST_OK;
				end
			end
			if (a.st == ST_FULL)
				n_full++;
			if (a.st == ST_IGNORED)
				n_ignored++;
			if (a.len != 0)
				n_hits++;
			answers.push_back(a);
		endfunction

		task check(logic [LEN_W-1:0] len, logic [1:0] st);
			answer_t a;
			n_results++;
			if (answers.size() == 0) begin
				report($sformatf("unexpected result len=%0d status=%0d", len, st));
			end else begin
				a = answers.pop_front();
				if (len !== a.len)
					report($sformatf("match_len %0d, expected %0d", len, a.len));
				if (st !== a.st)
					report($sformatf("status %0d, expected %0d", st, a.st));
			end
		endtask
	endclass

	localparam int LIMIT = 500000;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [1:0]        cmd;
	logic [LTR_W-1:0]  letter;
	logic              pattern_end;
	logic              text_start;
	logic              done;
	logic [LEN_W-1:0]  match_len;
	logic [1:0]        status;

	aco_scoreboard sb;
	int            idle_cycles = 0;
	int            n_items;

	aho_corasick_matcher dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.letter(letter),
		.pattern_end(pattern_end),
		.text_start(text_start),
		.done(done),
		.match_len(match_len),
		.status(status)
	);

	initial clk = 0;
	always #4 clk = ~clk;

	task automatic send(logic [1:0] c, logic [LTR_W-1:0] l, logic pe, logic ts);
		int g;
		g = $urandom_range(0, 1) ? 0 : $urandom_range(0, 3);
		@(negedge clk);
		if (g > 0) begin
			start <= 1'b0;
			repeat (g) @(negedge clk);
		end
		cmd <= c;
		letter <= l;
		pattern_end <= pe;
		text_start <= ts;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		sb.note(c, l, pe, ts);
		n_items++;
	endtask

	function automatic logic [LTR_W-1:0] pick_letter();
		int r;
		r = $urandom_range(0, 99);
		if (r < 4)
			return LTR_W'($urandom_range(ALPHABET, 31));
		else if (r < 70)
			return LTR_W'($urandom_range(0, 3));
		return LTR_W'($urandom_range(0, ALPHABET - 1));
	endfunction

	task automatic send_pattern();
		int n;
		n = $urandom_range(4, 16);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 49) == 0)
				send(CMD_RSVD, LTR_W'($urandom), 1'($urandom), 1'($urandom));
			send(CMD_INSERT, pick_letter(), i == n - 1, 1'($urandom));
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && done)
			sb.check(match_len, status);
	end

	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= LIMIT) begin
			$display("Watchdog expired with %0d results pending", sb.answers.size());
			$display("aho_corasick_matcher_tb NOT OK");
			$finish;
		end
	end

	initial begin
		int extra;
		sb = new();
		n_items = 0;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = CMD_INSERT;
		letter = '0;
		pattern_end = 1'b0;
		text_start = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send(CMD_MATCH, 5'd0, 1'b0, 1'b1);
		send(CMD_RSVD, 5'd31, 1'b1, 1'b1);
		send(CMD_INSERT, 5'd31, 1'b1, 1'b0);
		send(CMD_INSERT, 5'd26, 1'b1, 1'b1);
		send(CMD_INSERT, 5'd0, 1'b1, 1'b1);
		send(CMD_INSERT, 5'd1, 1'b0, 1'b0);
		send(CMD_INSERT, 5'd0, 1'b1, 1'b0);
		send(CMD_INSERT, 5'd25, 1'b0, 1'b1);
		send(CMD_INSERT, 5'd25, 1'b1, 1'b0);
		send(CMD_INSERT, 5'd2, 1'b0, 1'b0);
		send(CMD_INSERT, 5'd1, 1'b0, 1'b0);
		send(CMD_INSERT, 5'd0, 1'b1, 1'b0);
		send(CMD_INSERT, 5'd1, 1'b1, 1'b0);

		extra = 0;
		while (extra < 5) begin
			send_pattern();
			if (sb.node_cnt >= NODES - 1)
				extra++;
		end
		send(CMD_INSERT, 5'd7, 1'b0, 1'b0);
		send(CMD_INSERT, 5'd8, 1'b0, 1'b0);
		send(CMD_BUILD, 5'd0, 1'b1, 1'b1);
		send(CMD_BUILD, 5'd0, 1'b0, 1'b0);
		send(CMD_INSERT, 5'd0, 1'b1, 1'b0);

		send(CMD_MATCH, 5'd2, 1'b1, 1'b1);
		send(CMD_MATCH, 5'd1, 1'b0, 1'b0);
		send(CMD_MATCH, 5'd0, 1'b1, 1'b0);
		send(CMD_MATCH, 5'd25, 1'b0, 1'b0);
		send(CMD_MATCH, 5'd25, 1'b0, 1'b1);
		send(CMD_MATCH, 5'd31, 1'b1, 1'b1);
		for (int i = 0; i < 100; i++) begin
			case ($urandom_range(0, 39))
				0: send(CMD_RSVD, LTR_W'($urandom), 1'($urandom), 1'($urandom));
				1: send(CMD_INSERT, LTR_W'($urandom), 1'($urandom), 1'($urandom));
				2: send(CMD_BUILD, LTR_W'($urandom), 1'($urandom), 1'($urandom));
				default: send(CMD_MATCH, pick_letter(), 1'($urandom),
					$urandom_range(0, 9) == 0);
			endcase
		end
		@(negedge clk);
		start <= 1'b0;

		while (sb.answers.size() > 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("Sent %0d transactions, %0d trie nodes, %0d dropped letters,",
			n_items, sb.node_cnt, sb.n_full);
		$display("%0d ignored commands and %0d text letters ending a pattern.",
			sb.n_ignored, sb.n_hits);
		if (sb.errors == 0 && sb.answers.size() == 0)
			$display("aho_corasick_matcher_tb OK");
		else
			$display("aho_corasick_matcher_tb NOT OK");
		$finish;
	end
endmodule
